FILE: src/mrf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus read request framer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int HDR_LEN   = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [7:0] t_byte;

    // Header bytes in transmit order, element 0 goes out first
    typedef t_byte [HDR_LEN-1:0]   t_hdr;
    typedef t_byte [FRAME_LEN-1:0] t_frame;

    typedef logic [$clog2(FRAME_LEN)-1:0] t_byte_idx;

    localparam t_byte_idx LAST_IDX = t_byte_idx'(FRAME_LEN - 1);

    typedef struct packed {
        t_byte       slave_id;
        t_byte       function_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
    } t_cfg;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_SLAVE_ID       = 2'd0;
    localparam t_reg_idx REG_FUNCTION_CODE  = 2'd1;
    localparam t_reg_idx REG_START_ADDRESS  = 2'd2;
    localparam t_reg_idx REG_REGISTER_COUNT = 2'd3;

    localparam t_byte       RST_SLAVE_ID       = 8'd1;
    localparam t_byte       RST_FUNCTION_CODE  = 8'd3;
    localparam logic [15:0] RST_START_ADDRESS  = 16'd0;
    localparam logic [15:0] RST_REGISTER_COUNT = 16'd1;

    // Fold one byte into a reflected CRC-16/Modbus, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input t_byte data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/mrf_cfg_regs.sv
// APB-style configuration registers of the Modbus read request framer.
// Depends on mrf_pkg for the register map, reset values and the t_cfg struct.
`default_nettype none

module mrf_cfg_regs
    import mrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access phase, keep the low bits of each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_id       <= RST_SLAVE_ID;
            r_cfg.function_code  <= RST_FUNCTION_CODE;
            r_cfg.start_address  <= RST_START_ADDRESS;
            r_cfg.register_count <= RST_REGISTER_COUNT;
        end else if (w_wr) begin
            case (w_idx)
                REG_SLAVE_ID:       r_cfg.slave_id       <= pwdata[7:0];
                REG_FUNCTION_CODE:  r_cfg.function_code  <= pwdata[7:0];
                REG_START_ADDRESS:  r_cfg.start_address  <= pwdata[15:0];
                REG_REGISTER_COUNT: r_cfg.register_count <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_SLAVE_ID:       prdata = {24'h0, r_cfg.slave_id};
            REG_FUNCTION_CODE:  prdata = {24'h0, r_cfg.function_code};
            REG_START_ADDRESS:  prdata = {16'h0, r_cfg.start_address};
            REG_REGISTER_COUNT: prdata = {16'h0, r_cfg.register_count};
            default:            prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/mrf_crc_pipe.sv
// Six-stage CRC pipeline: each stage folds one header byte into the running CRC.
// Depends on mrf_pkg for crc_byte and the header and frame types.
`default_nettype none

module mrf_crc_pipe
    import mrf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cfg i_cfg,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_frame    o_frame
);

    localparam int STAGES = HDR_LEN;

    logic [STAGES-1:0] r_vld;
    t_hdr              r_hdr [STAGES];
    logic [15:0]       r_crc [STAGES];
    logic [STAGES:0]   w_rdy;
    t_hdr              w_hdr_in;

    // Lay out the header in transmit order
    assign w_hdr_in[0] = i_cfg.slave_id;
    assign w_hdr_in[1] = i_cfg.function_code;
    assign w_hdr_in[2] = i_cfg.start_address[15:8];
    assign w_hdr_in[3] = i_cfg.start_address[7:0];
    assign w_hdr_in[4] = i_cfg.register_count[15:8];
    assign w_hdr_in[5] = i_cfg.register_count[7:0];

    // A stage advances when it is empty or its successor advances
    assign w_rdy[STAGES] = i_ready;
    for (genvar k = 0; k < STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    // Move valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Fold header byte k into the CRC at stage k
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_hdr[0] <= w_hdr_in;
            r_crc[0] <= crc_byte(CRC_INIT, w_hdr_in[0]);
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_rdy[k]) begin
                r_hdr[k] <= r_hdr[k-1];
                r_crc[k] <= crc_byte(r_crc[k-1], r_hdr[k-1][k]);
            end
        end
    end

    // Append the CRC, low byte first
    always_comb begin
        for (int k = 0; k < HDR_LEN; k++) begin
            o_frame[k] = r_hdr[STAGES-1][k];
        end
        o_frame[HDR_LEN]   = r_crc[STAGES-1][7:0];
        o_frame[HDR_LEN+1] = r_crc[STAGES-1][15:8];
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_ready = w_rdy[0];

endmodule

`default_nettype wire

FILE: src/mrf_serializer.sv
// Output register that sends a finished frame one byte per item.
// Depends on mrf_pkg for the frame and byte index types.
`default_nettype none

module mrf_serializer
    import mrf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_in_ready,
    input  wire t_frame i_frame,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_byte       o_frame_byte,
    output t_byte_idx   o_byte_index,
    output logic        o_last_byte
);

    logic      r_valid;
    t_byte_idx r_idx;
    t_frame    r_frame;
    logic      w_take;
    logic      w_last;

    assign w_last     = (r_idx == LAST_IDX);
    assign o_in_ready = !r_valid || (i_ready && w_last);
    assign w_take     = i_valid && o_in_ready;

    // Load a new frame, or advance to the next byte when one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + t_byte_idx'(1);
            end
        end
    end

    // Hold the frame bytes
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_frame <= i_frame;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_frame[r_idx];
    assign o_byte_index = r_idx;
    assign o_last_byte  = w_last;

endmodule

`default_nettype wire

FILE: src/modbus_read_request_framer.sv
// Modbus RTU read request framer: eight bytes per trigger, CRC-16/Modbus appended.
// The trigger item passes through the six CRC stages and then the output register before
// its first byte is offered; back-pressure can stall it on the way.
// Throughput: one byte per cycle while i_out_ready is high, set by the single output
// register; the six CRC stages take a new item every cycle unless stalled.
// Reset (synchronous, active low) empties the pipeline and output register and
// loads the configuration reset values.
`default_nettype none

module modbus_read_request_framer
    import mrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_trigger,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_frame_byte,
    output logic [2:0]       o_byte_index,
    output logic             o_last_byte,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg   w_cfg;
    logic   w_pipe_valid;
    logic   w_pipe_ready;
    t_frame w_frame;

    mrf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Drop items whose trigger is low
    mrf_crc_pipe u_crc_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid && i_trigger),
        .o_ready (o_in_ready),
        .i_cfg   (w_cfg),
        .o_valid (w_pipe_valid),
        .i_ready (w_pipe_ready),
        .o_frame (w_frame)
    );

    mrf_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_pipe_valid),
        .o_in_ready   (w_pipe_ready),
        .i_frame      (w_frame),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

`ifndef SYNTHESIS
    // A taken byte that is not the last is followed by the next byte of the frame
    a_byte_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_byte) |=>
            (o_out_valid && o_byte_index == 3'($past(o_byte_index) + 3'd1)))
        else $error("frame byte sequence broken");

    // After the last byte the next offered byte opens a frame
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_byte) |=>
            (!o_out_valid || o_byte_index == 3'd0))
        else $error("frame does not restart at byte zero");

    // The end-of-frame flag marks exactly the eighth byte
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_byte == (o_byte_index == 3'd7)))
        else $error("last byte flag misplaced");
`endif

endmodule

`default_nettype wire
